@@ rtl/ppd_pkg.sv @@
// Shared types and constants for the point to polygon distance block.
package ppd_pkg;

    localparam int OP_W   = 2;
    localparam int CRD_W  = 32;
    localparam int DIST_W = 33;
    localparam int STAT_W = 2;

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Status codes of a result word.
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FEW  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Classified operation carried through the queue.
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [CRD_W-1:0] coord_x;
        logic signed [CRD_W-1:0] coord_y;
    } in_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              inside_res;
        logic [STAT_W-1:0] status;
    } res_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ rtl/ppd_front.sv @@
// Front end: accepts input words, classifies the operation and keeps the low CB bits of each coordinate.
module ppd_front #(
    parameter int CB = 32
) (
    input  logic             start,
    output logic             busy,
    input  ppd_pkg::in_word_t item,
    input  ppd_pkg::q_stat_t q_stat,
    output logic             push,
    output logic [2*CB+1:0]  push_data
);

    localparam int RW = (CB > ppd_pkg::CRD_W) ? CB : ppd_pkg::CRD_W;

    logic [RW-1:0]    raw_x;
    logic [RW-1:0]    raw_y;
    ppd_pkg::kind_t   kind;

    // The queue being full is the only reason to hold off a new word.
    assign busy = q_stat.full;
    assign push = start && !q_stat.full;

    // Coordinates keep their low CB bits, taken as a signed value.
    assign raw_x = RW'($unsigned(item.coord_x));
    assign raw_y = RW'($unsigned(item.coord_y));

    always_comb
    begin
        unique case (item.operation)
            ppd_pkg::OP_CLEAR:  kind = ppd_pkg::KIND_CLEAR;
            ppd_pkg::OP_APPEND: kind = ppd_pkg::KIND_APPEND;
            ppd_pkg::OP_QUERY:  kind = ppd_pkg::KIND_QUERY;
            default:            kind = ppd_pkg::KIND_NOP;
        endcase
    end

    assign push_data = {kind, raw_x[CB-1:0], raw_y[CB-1:0]};

endmodule

@@ rtl/ppd_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
module ppd_queue #(
    parameter int W = 66
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [W-1:0]     push_data,
    input  logic             pop,
    output logic [W-1:0]     head,
    output ppd_pkg::q_stat_t q_stat
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         do_push;
    logic         do_pop;

    assign q_stat.full  = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/ppd_back.sv @@
// Back end: vertex store, edge-walking sequencer with shared multiplier, divider and root.
module ppd_back #(
    parameter int MAXV = 64,
    parameter int CB   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2*CB+1:0]     head,
    input  ppd_pkg::q_stat_t    q_stat,
    output logic                pop,
    output logic                done,
    output ppd_pkg::res_word_t  result
);

    localparam int MW   = CB + 1;
    localparam int PW   = 2 * MW;
    localparam int QW   = 2 * MW;
    localparam int SW   = 2 * MW + 1;
    localparam int W4   = 4 * MW;
    localparam int IW   = $clog2(MAXV);
    localparam int CW   = $clog2(MAXV + 1);
    localparam int NW   = $clog2(QW + 1);
    localparam int RW2  = (MW > ppd_pkg::DIST_W) ? MW : ppd_pkg::DIST_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_RD   = 9'b000000010,
        ST_LD   = 9'b000000100,
        ST_MUL  = 9'b000001000,
        ST_ACC  = 9'b000010000,
        ST_EVAL = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_CMP  = 9'b010000000,
        ST_SQRT = 9'b100000000
    } state_t;

    typedef enum logic [3:0] {
        STEP_VXX  = 4'd0,
        STEP_VYY  = 4'd1,
        STEP_WXVX = 4'd2,
        STEP_WYVY = 4'd3,
        STEP_WXVY = 4'd4,
        STEP_WYVX = 4'd5,
        STEP_N1   = 4'd6,
        STEP_N2   = 4'd7,
        STEP_LL   = 4'd8,
        STEP_LH   = 4'd9,
        STEP_HH   = 4'd10
    } step_t;

    // Vertex store.
    logic signed [CB-1:0] vx_mem [MAXV];
    logic signed [CB-1:0] vy_mem [MAXV];
    logic signed [CB-1:0] rdx_reg;
    logic signed [CB-1:0] rdy_reg;
    logic                 mem_we;

    state_t               state_reg, state_next;
    step_t                step_reg, step_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic signed [CB-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [CB-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic signed [CB-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [MW-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [MW-1:0] wx_reg, wx_next, wy_reg, wy_next;
    logic signed [MW-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic                 ycross_reg, ycross_next;
    logic                 use_u_reg, use_u_next;
    logic                 mode_c_reg, mode_c_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic                 psign_reg, psign_next;
    logic [QW-1:0]        len2_reg, len2_next;
    logic signed [SW-1:0] dot_reg, dot_next;
    logic signed [SW-1:0] crs_reg, crs_next;
    logic [QW-1:0]        num_reg, num_next;
    logic [W4-1:0]        n4_reg, n4_next;
    logic [QW-1:0]        dr_reg, dr_next;
    logic [QW-1:0]        dlo_reg, dlo_next;
    logic [QW-1:0]        quot_reg, quot_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [QW-1:0]        best_reg, best_next;
    logic                 inside_reg, inside_next;
    logic                 parity_reg, parity_next;
    logic [QW-1:0]        sx_reg, sx_next;
    logic [MW:0]          srem_reg, srem_next;
    logic [MW-1:0]        sroot_reg, sroot_next;
    logic                 done_reg, done_next;
    ppd_pkg::res_word_t   res_reg, res_next;

    // Decoded head of the queue.
    ppd_pkg::kind_t       h_kind;
    logic signed [CB-1:0] h_x;
    logic signed [CB-1:0] h_y;

    // Multiplier operands and helpers.
    logic [MW-1:0]        ma;
    logic [MW-1:0]        mb;
    logic                 msign;
    logic signed [SW-1:0] pext;
    logic signed [SW-1:0] pval;
    logic [PW-1:0]        cmag;
    logic [W4-1:0]        n4_sum;
    logic [QW:0]          dtrial;
    logic                 dfit;
    logic [MW+1:0]        srem_t;
    logic [MW+1:0]        strial;
    logic [MW-1:0]        sroot_new;
    logic [RW2-1:0]       root_ext;
    logic [QW-1:0]        q_val;
    logic                 q_zero;
    logic [QW-1:0]        best_new;
    logic                 last_edge;

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        mag = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    assign h_kind = ppd_pkg::kind_t'(head[2*CB+1:2*CB]);
    assign h_x    = head[2*CB-1:CB];
    assign h_y    = head[CB-1:0];
    assign pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign mem_we = pop && (h_kind == ppd_pkg::KIND_APPEND) && (count_reg < CW'(MAXV));

    assign done   = done_reg;
    assign result = res_reg;

    // Operand selection for the shared multiplier.
    assign cmag = crs_reg[SW-1] ? PW'(-crs_reg) : PW'(crs_reg);

    always_comb
    begin
        ma    = mag(vx_reg);
        mb    = mag(vx_reg);
        msign = 1'b0;
        unique case (step_reg)
            STEP_VXX:
            begin
                ma = mag(vx_reg);
                mb = mag(vx_reg);
            end
            STEP_VYY:
            begin
                ma = mag(vy_reg);
                mb = mag(vy_reg);
            end
            STEP_WXVX:
            begin
                ma    = mag(wx_reg);
                mb    = mag(vx_reg);
                msign = wx_reg[MW-1] ^ vx_reg[MW-1];
            end
            STEP_WYVY:
            begin
                ma    = mag(wy_reg);
                mb    = mag(vy_reg);
                msign = wy_reg[MW-1] ^ vy_reg[MW-1];
            end
            STEP_WXVY:
            begin
                ma    = mag(wx_reg);
                mb    = mag(vy_reg);
                msign = wx_reg[MW-1] ^ vy_reg[MW-1];
            end
            STEP_WYVX:
            begin
                ma    = mag(wy_reg);
                mb    = mag(vx_reg);
                msign = wy_reg[MW-1] ^ vx_reg[MW-1];
            end
            STEP_N1:
            begin
                ma = use_u_reg ? mag(ux_reg) : mag(wx_reg);
                mb = ma;
            end
            STEP_N2:
            begin
                ma = use_u_reg ? mag(uy_reg) : mag(wy_reg);
                mb = ma;
            end
            STEP_LL:
            begin
                ma = cmag[MW-1:0];
                mb = cmag[MW-1:0];
            end
            STEP_LH:
            begin
                ma = cmag[MW-1:0];
                mb = cmag[PW-1:MW];
            end
            STEP_HH:
            begin
                ma = cmag[PW-1:MW];
                mb = cmag[PW-1:MW];
            end
            default:
            begin
                ma = mag(vx_reg);
                mb = mag(vx_reg);
            end
        endcase
    end

    // Signed product, square accumulation and one step of each iterative unit.
    assign pext      = $signed({1'b0, prod_reg});
    assign pval      = psign_reg ? -pext : pext;
    assign n4_sum    = n4_reg + (W4'(prod_reg) << (2 * MW));
    assign dtrial    = {dr_reg, dlo_reg[QW-1]};
    assign dfit      = (dtrial >= {1'b0, len2_reg});
    assign srem_t    = {srem_reg[MW-1:0], sx_reg[QW-1:QW-2]};
    assign strial    = {sroot_reg, 2'b01};
    assign sroot_new = {sroot_reg[MW-2:0], (srem_t >= strial)};
    assign root_ext  = RW2'(sroot_new);
    assign q_val     = mode_c_reg ? quot_reg : num_reg;
    assign q_zero    = mode_c_reg ? (crs_reg == '0) : (num_reg == '0);
    assign best_new  = (q_val < best_reg) ? q_val : best_reg;
    assign last_edge = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        wx_next     = wx_reg;
        wy_next     = wy_reg;
        ux_next     = ux_reg;
        uy_next     = uy_reg;
        ycross_next = ycross_reg;
        use_u_next  = use_u_reg;
        mode_c_next = mode_c_reg;
        prod_next   = prod_reg;
        psign_next  = psign_reg;
        len2_next   = len2_reg;
        dot_next    = dot_reg;
        crs_next    = crs_reg;
        num_next    = num_reg;
        n4_next     = n4_reg;
        dr_next     = dr_reg;
        dlo_next    = dlo_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        best_next   = best_reg;
        inside_next = inside_reg;
        parity_next = parity_reg;
        sx_next     = sx_reg;
        srem_next   = srem_reg;
        sroot_next  = sroot_reg;
        done_next   = 1'b0;
        res_next    = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    res_next = '0;
                    unique case (h_kind)
                        ppd_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        ppd_pkg::KIND_APPEND:
                        begin
                            if (count_reg < CW'(MAXV))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                res_next.status = ppd_pkg::STATUS_FULL;
                            end
                            done_next = 1'b1;
                        end
                        ppd_pkg::KIND_QUERY:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                res_next.status = ppd_pkg::STATUS_FEW;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                px_next     = h_x;
                                py_next     = h_y;
                                idx_next    = '0;
                                best_next   = '1;
                                inside_next = 1'b0;
                                parity_next = 1'b0;
                                state_next  = ST_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_LD;
            end
            ST_LD:
            begin
                if (idx_reg == '0)
                begin
                    // First vertex only opens the ring.
                    ex_next    = rdx_reg;
                    ey_next    = rdy_reg;
                    idx_next   = IW'(1);
                    state_next = ST_RD;
                end
                else
                begin
                    bx_next     = rdx_reg;
                    by_next     = rdy_reg;
                    vx_next     = MW'(ex_reg) - MW'(rdx_reg);
                    vy_next     = MW'(ey_reg) - MW'(rdy_reg);
                    wx_next     = MW'(px_reg) - MW'(rdx_reg);
                    wy_next     = MW'(py_reg) - MW'(rdy_reg);
                    ux_next     = MW'(px_reg) - MW'(ex_reg);
                    uy_next     = MW'(py_reg) - MW'(ey_reg);
                    ycross_next = ((rdy_reg >= py_reg) && (ey_reg < py_reg))
                               || ((ey_reg >= py_reg) && (rdy_reg < py_reg));
                    step_next   = STEP_VXX;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PW'(ma) * PW'(mb);
                psign_next = msign;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_MUL;
                unique case (step_reg)
                    STEP_VXX:
                    begin
                        len2_next = prod_reg;
                        step_next = STEP_VYY;
                    end
                    STEP_VYY:
                    begin
                        len2_next = len2_reg + prod_reg;
                        step_next = STEP_WXVX;
                    end
                    STEP_WXVX:
                    begin
                        dot_next  = pval;
                        step_next = STEP_WYVY;
                    end
                    STEP_WYVY:
                    begin
                        dot_next  = dot_reg + pval;
                        step_next = STEP_WXVY;
                    end
                    STEP_WXVY:
                    begin
                        crs_next  = pval;
                        step_next = STEP_WYVX;
                    end
                    STEP_WYVX:
                    begin
                        crs_next   = crs_reg - pval;
                        state_next = ST_EVAL;
                    end
                    STEP_N1:
                    begin
                        num_next  = prod_reg;
                        step_next = STEP_N2;
                    end
                    STEP_N2:
                    begin
                        num_next   = num_reg + prod_reg;
                        state_next = ST_CMP;
                    end
                    STEP_LL:
                    begin
                        n4_next   = W4'(prod_reg);
                        step_next = STEP_LH;
                    end
                    STEP_LH:
                    begin
                        n4_next   = n4_reg + (W4'(prod_reg) << (MW + 1));
                        step_next = STEP_HH;
                    end
                    STEP_HH:
                    begin
                        // The quotient fits QW bits, so the upper half is below the divisor.
                        dr_next    = n4_sum[W4-1:QW];
                        dlo_next   = n4_sum[QW-1:0];
                        quot_next  = '0;
                        cnt_next   = NW'(QW);
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EVAL:
            begin
                // Ray crossing test on edges that straddle the point's row.
                if (ycross_reg)
                begin
                    if (crs_reg == '0)
                    begin
                        inside_next = 1'b1;
                    end
                    else if ((crs_reg[SW-1] && !vy_reg[MW-1] && (vy_reg != '0))
                          || (!crs_reg[SW-1] && vy_reg[MW-1]))
                    begin
                        parity_next = !parity_reg;
                    end
                end
                // Pick end point or perpendicular measure.
                if ((len2_reg == '0) || dot_reg[SW-1])
                begin
                    use_u_next  = 1'b0;
                    mode_c_next = 1'b0;
                    step_next   = STEP_N1;
                end
                else if (dot_reg > $signed({1'b0, len2_reg}))
                begin
                    use_u_next  = 1'b1;
                    mode_c_next = 1'b0;
                    step_next   = STEP_N1;
                end
                else
                begin
                    mode_c_next = 1'b1;
                    step_next   = STEP_LL;
                end
                state_next = ST_MUL;
            end
            ST_DIV:
            begin
                // One quotient bit of cross squared over length squared.
                dr_next   = dfit ? QW'(dtrial - {1'b0, len2_reg}) : dtrial[QW-1:0];
                dlo_next  = {dlo_reg[QW-2:0], 1'b0};
                quot_next = {quot_reg[QW-2:0], dfit};
                cnt_next  = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                best_next = best_new;
                if (q_zero)
                begin
                    inside_next = 1'b1;
                end
                if (last_edge)
                begin
                    if (inside_reg || q_zero || parity_reg)
                    begin
                        res_next            = '0;
                        res_next.inside_res = 1'b1;
                        done_next           = 1'b1;
                        state_next          = ST_IDLE;
                    end
                    else
                    begin
                        sx_next    = best_new;
                        srem_next  = '0;
                        sroot_next = '0;
                        cnt_next   = NW'(MW);
                        state_next = ST_SQRT;
                    end
                end
                else
                begin
                    ex_next    = bx_reg;
                    ey_next    = by_reg;
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_RD;
                end
            end
            ST_SQRT:
            begin
                // One root bit per cycle, two radicand bits at a time.
                srem_next  = (srem_t >= strial) ? (MW+1)'(srem_t - strial) : (MW+1)'(srem_t);
                sroot_next = sroot_new;
                sx_next    = {sx_reg[QW-3:0], 2'b00};
                cnt_next   = cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                begin
                    res_next          = '0;
                    res_next.distance = (root_ext > RW2'(ppd_pkg::DIST_MAX))
                                      ? ppd_pkg::DIST_MAX : root_ext[ppd_pkg::DIST_W-1:0];
                    done_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        wx_reg     <= wx_next;
        wy_reg     <= wy_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        ycross_reg <= ycross_next;
        use_u_reg  <= use_u_next;
        mode_c_reg <= mode_c_next;
        prod_reg   <= prod_next;
        psign_reg  <= psign_next;
        len2_reg   <= len2_next;
        dot_reg    <= dot_next;
        crs_reg    <= crs_next;
        num_reg    <= num_next;
        n4_reg     <= n4_next;
        dr_reg     <= dr_next;
        dlo_reg    <= dlo_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        best_reg   <= best_next;
        inside_reg <= inside_next;
        parity_reg <= parity_next;
        sx_reg     <= sx_next;
        srem_reg   <= srem_next;
        sroot_reg  <= sroot_next;
        res_reg    <= res_next;
    end

    // Vertex store write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vx_mem[count_reg[IW-1:0]] <= h_x;
            vy_mem[count_reg[IW-1:0]] <= h_y;
        end
        rdx_reg <= vx_mem[idx_reg];
        rdy_reg <= vy_mem[idx_reg];
    end

endmodule

@@ rtl/point_polygon_distance.sv @@
// Top level of the point to polygon distance block.
//
// Words are taken while busy is low; a two-entry queue lets the next word in while the
// back end works. Clear, append and unused codes are handled in the idle state. A query
// walks the edges between consecutive stored vertices through one shared multiplier; an edge
// measured perpendicularly also passes through a bit-serial divider, and an outside
// point then needs a square root. Every word yields one result, shown on result for
// the single cycle that done is high; the receiver cannot stall it, so it must take
// each result in that cycle.
module point_polygon_distance #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ppd_pkg::in_word_t  item,
    output logic               done,
    output ppd_pkg::res_word_t result
);

    localparam int QDW = 2 * COORD_BITS + 2;

    logic             push;
    logic [QDW-1:0]   push_data;
    logic             pop;
    logic [QDW-1:0]   head;
    ppd_pkg::q_stat_t q_stat;

    ppd_front #(
        .CB(COORD_BITS)
    ) u_front (
        .start    (start),
        .busy     (busy),
        .item     (item),
        .q_stat   (q_stat),
        .push     (push),
        .push_data(push_data)
    );

    ppd_queue #(
        .W(QDW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ppd_back #(
        .MAXV(MAX_VERTICES),
        .CB  (COORD_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .q_stat(q_stat),
        .pop   (pop),
        .done  (done),
        .result(result)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the point to polygon distance block.
`timescale 1ns / 1ps

module tb_top;

    // Wide signed type: products of squared lengths need far more than 64 bits.
    typedef logic signed [255:0] big_t;

    typedef struct {
        ppd_pkg::in_word_t word;
        bit                drain;
    } send_t;

    localparam int  MAX_VERTS   = 64;
    localparam int  IDLE_PCT    = 12;
    localparam int  SETTLE_CYC  = 200;
    localparam longint CYCLE_LIMIT = 40_000_000;

    // Operation code that the block ignores.
    localparam logic [ppd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    ppd_pkg::in_word_t  item;
    logic               done;
    ppd_pkg::res_word_t result;

    point_polygon_distance dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Predictor state: the polygon as the block should hold it.
    logic signed [ppd_pkg::CRD_W-1:0] poly_x [MAX_VERTS];
    logic signed [ppd_pkg::CRD_W-1:0] poly_y [MAX_VERTS];
    int                               poly_count = 0;

    send_t              word_queue [$];
    ppd_pkg::res_word_t expected_results [$];
    int                 mismatch_count = 0;
    int                 accepted_count = 0;
    longint             cycle_count = 0;
    send_t              next_word;
    ppd_pkg::res_word_t exp_word;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Largest d below 2^DIST_W with d*d*den <= num.
    function automatic logic [ppd_pkg::DIST_W-1:0] root_floor(big_t num, big_t den);
        logic [ppd_pkg::DIST_W-1:0] d;
        logic [ppd_pkg::DIST_W-1:0] cand;
        big_t                       wc;
        d = '0;
        for (int b = ppd_pkg::DIST_W - 1; b >= 0; b--)
        begin
            cand = d | (33'd1 << b);
            wc   = big_t'({1'b0, cand});
            if (wc * wc * den <= num)
                d = cand;
        end
        return d;
    endfunction

    // Work out the result of one word and update the polygon.
    function automatic ppd_pkg::res_word_t polygon_result(ppd_pkg::in_word_t w);
        ppd_pkg::res_word_t r;
        big_t px, py, bx, by, ex, ey, vx, vy, wx, wy;
        big_t len2, dot, crs, num, den;
        logic [ppd_pkg::DIST_W-1:0] best;
        logic [ppd_pkg::DIST_W-1:0] d;
        bit   on_poly;
        int   crossings;
        r = '0;
        px = big_t'(w.coord_x);
        py = big_t'(w.coord_y);
        case (w.operation)
            ppd_pkg::OP_CLEAR:
                poly_count = 0;
            ppd_pkg::OP_APPEND:
                if (poly_count >= MAX_VERTS)
                    r.status = ppd_pkg::STATUS_FULL;
                else
                begin
                    poly_x[poly_count] = w.coord_x;
                    poly_y[poly_count] = w.coord_y;
                    poly_count++;
                end
            ppd_pkg::OP_QUERY:
                if (poly_count < 2)
                    r.status = ppd_pkg::STATUS_FEW;
                else
                begin
                    best      = ppd_pkg::DIST_MAX;
                    on_poly   = 0;
                    crossings = 0;
                    for (int i = 1; i < poly_count; i++)
                    begin
                        bx   = big_t'(poly_x[i]);
                        by   = big_t'(poly_y[i]);
                        ex   = big_t'(poly_x[i-1]);
                        ey   = big_t'(poly_y[i-1]);
                        vx   = ex - bx;
                        vy   = ey - by;
                        wx   = px - bx;
                        wy   = py - by;
                        len2 = vx * vx + vy * vy;
                        dot  = wx * vx + wy * vy;
                        crs  = wx * vy - wy * vx;
                        den  = 1;
                        // Edge straddles the ray's height: count a crossing to the right.
                        if ((by >= py && ey < py) || (ey >= py && by < py))
                        begin
                            if (crs == 0)
                                on_poly = 1;
                            else if ((crs < 0 && vy > 0) || (crs > 0 && vy < 0))
                                crossings++;
                        end
                        // Distance to the segment: an end point or the perpendicular.
                        if (len2 == 0 || dot < 0)
                            num = wx * wx + wy * wy;
                        else if (dot > len2)
                            num = (px - ex) * (px - ex) + (py - ey) * (py - ey);
                        else
                        begin
                            num = crs * crs;
                            den = len2;
                        end
                        if (num == 0)
                            on_poly = 1;
                        d = root_floor(num, den);
                        if (d < best)
                            best = d;
                    end
                    if (crossings % 2 == 1)
                        on_poly = 1;
                    r.distance   = on_poly ? '0 : best;
                    r.inside_res = on_poly;
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_word(logic [ppd_pkg::OP_W-1:0] op,
                            logic signed [ppd_pkg::CRD_W-1:0] x,
                            logic signed [ppd_pkg::CRD_W-1:0] y, bit drain = 0);
        send_t s;
        s.word.operation = op;
        s.word.coord_x   = x;
        s.word.coord_y   = y;
        s.drain          = drain;
        word_queue.push_back(s);
    endtask

    // Coordinates: mostly on a coarse grid so vertices and edges get hit,
    // sometimes with a fraction, sometimes any 32-bit value.
    function automatic logic signed [ppd_pkg::CRD_W-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return $urandom;
        else if (sel < 75)
            return ($urandom_range(0, 40) - 20) <<< 16;
        else
            return (($urandom_range(0, 80) - 40) <<< 16) + $urandom_range(0, 65535);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Driver: a word is taken at an edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(polygon_result(item));
                accepted_count++;
            end
            if (!start || !busy)
            begin
                if (word_queue.size() > 0
                    && !(word_queue[0].drain && expected_results.size() != 0)
                    && !((accepted_count < 300 || accepted_count >= 500)
                         && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    next_word = word_queue.pop_front();
                    item  <= next_word.word;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
            end
            else
            begin
                exp_word = expected_results.pop_front();
                if (result.distance !== exp_word.distance)
                    report_mismatch("distance", result.distance, exp_word.distance);
                if (result.inside_res !== exp_word.inside_res)
                    report_mismatch("inside_res", result.inside_res, exp_word.inside_res);
                if (result.status !== exp_word.status)
                    report_mismatch("status", result.status, exp_word.status);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("point_polygon_distance verification failed");
            $finish;
        end
    end

    initial
    begin
        int nverts;
        int nq;
        int big_poly;
        int sent;
        rst_n = 1'b0;

        // Directed: too few vertices, unused code, a square, boundary cases.
        add_word(ppd_pkg::OP_QUERY, 0, 0);
        add_word(ppd_pkg::OP_APPEND, 32'sh0001_0000, 0);
        add_word(ppd_pkg::OP_QUERY, 0, 0);
        add_word(OP_UNUSED, -1, -1);
        add_word(ppd_pkg::OP_CLEAR, 0, 0);
        add_word(ppd_pkg::OP_APPEND, 0, 0);
        add_word(ppd_pkg::OP_APPEND, 32'sh000A_0000, 0);
        add_word(ppd_pkg::OP_APPEND, 32'sh000A_0000, 32'sh000A_0000);
        add_word(ppd_pkg::OP_APPEND, 32'sh000A_0000, 32'sh000A_0000);  // degenerate edge
        add_word(ppd_pkg::OP_APPEND, 0, 32'sh000A_0000);
        add_word(ppd_pkg::OP_APPEND, 0, 0);
        add_word(ppd_pkg::OP_QUERY, 32'sh0005_0000, 32'sh0005_0000);   // inside
        add_word(ppd_pkg::OP_QUERY, 32'sh000A_0000, 32'sh000A_0000);   // on a vertex
        add_word(ppd_pkg::OP_QUERY, 32'sh0003_8000, 0);                // on a horizontal edge
        add_word(ppd_pkg::OP_QUERY, 32'sh000A_0000, 32'sh0004_0000);   // on a vertical edge
        add_word(ppd_pkg::OP_QUERY, 32'sh0014_0000, 32'sh0005_0000);   // perpendicular
        add_word(ppd_pkg::OP_QUERY, 32'sh0010_0000, 32'sh0011_0000);   // nearest end
        add_word(ppd_pkg::OP_QUERY, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_word(ppd_pkg::OP_QUERY, 32'sh8000_0000, 32'sh8000_0000);
        add_word(ppd_pkg::OP_CLEAR, 0, 0, 1);
        add_word(ppd_pkg::OP_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000);
        add_word(ppd_pkg::OP_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF);  // open ring, one edge
        add_word(ppd_pkg::OP_QUERY, 32'sh8000_0000, 32'sh8000_0000);
        add_word(ppd_pkg::OP_QUERY, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        sent = word_queue.size();

        // Random polygons followed by queries; a few fill the store past full.
        while (sent < 1050)
        begin
            big_poly = ($urandom_range(0, 99) < 3);
            nverts   = big_poly ? $urandom_range(60, 68) : $urandom_range(2, 8);
            add_word(ppd_pkg::OP_CLEAR, $urandom, $urandom, ($urandom_range(0, 19) == 0));
            for (int v = 0; v < nverts; v++)
                add_word(ppd_pkg::OP_APPEND, rand_coord(), rand_coord());
            if ($urandom_range(0, 1))
                add_word(ppd_pkg::OP_APPEND,
                         word_queue[word_queue.size() - nverts].word.coord_x,
                         word_queue[word_queue.size() - nverts].word.coord_y);
            nq = big_poly ? 3 : $urandom_range(2, 10);
            for (int q = 0; q < nq; q++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_word(ppd_pkg::OP_W'($urandom_range(0, 3)), $urandom, $urandom);
                else
                    add_word(ppd_pkg::OP_QUERY, rand_coord(), rand_coord());
            end
            sent = word_queue.size();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all words sent, all results in, then let the block settle.
        while (word_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatch_count == 0)
            $display("point_polygon_distance verification clean");
        else
            $display("point_polygon_distance verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ppd_pkg.sv
rtl/ppd_front.sv
rtl/ppd_queue.sv
rtl/ppd_back.sv
rtl/point_polygon_distance.sv
tb/sv/tb_top.sv
